// ===== src/cross_kernel_convolution_macros.svh =====
// assertion macros for the cross kernel convolution block
// depends on nothing; taken in by the top level, empty when SYNTH is set
`ifndef CROSS_KERNEL_CONVOLUTION_MACROS_SVH
`define CROSS_KERNEL_CONVOLUTION_MACROS_SVH
`ifndef SYNTH
// same-cycle implication under asynchronous reset
`define CKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cross kernel convolution: implication failed");
// next-cycle implication under asynchronous reset
`define CKC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cross kernel convolution: next-cycle check failed");
`else
`define CKC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CKC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ckc_pkg.sv =====
// shared types, register codes and defaults of the cross kernel convolution block
// depends on nothing
package ckc_pkg;

	// default frame limits
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	// register and field widths
	localparam int CH_W       = 8;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// register reset values
	localparam logic [IMG_W_W-1:0] IMG_W_RESET = 12'd2048;
	localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd4096;
	localparam logic signed [CH_W-1:0] COEF_EDGE_RESET   = 8'sd0;
	localparam logic signed [CH_W-1:0] COEF_CENTRE_RESET = 8'sd1;

	// product and sum widths of the datapath
	localparam int PROD_W = 17;
	localparam int SUM_W  = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_LEFT    = 3'd2,
		REG_COEF_RIGHT   = 3'd3,
		REG_COEF_TOP     = 3'd4,
		REG_COEF_BOTTOM  = 3'd5,
		REG_COEF_CENTER  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// one rgb pixel, blue in the low byte
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic signed [CH_W-1:0] left;
		logic signed [CH_W-1:0] right;
		logic signed [CH_W-1:0] top;
		logic signed [CH_W-1:0] bottom;
		logic signed [CH_W-1:0] centre;
	} coef_t;

	// decode of an item that yields a result
	typedef struct packed {
		logic drain;
		logic interior;
		logic sel;
		logic last;
	} s1_t;

endpackage

// ===== src/ckc_ram.sv =====
// generic memory: one write port, two read ports with registered read data
// depends on nothing
module ckc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                       rdata_a,
	output logic [WIDTH-1:0]                       rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and read old contents on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== src/ckc_ctrl.sv =====
// raster position counters, item decode and line buffer addressing
// depends on ckc_pkg
module ckc_ctrl #(
	parameter int MAX_WIDTH  = ckc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ckc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              operation,
	input  logic [ckc_pkg::IMG_W_W-1:0]       image_width,
	input  logic [ckc_pkg::IMG_H_W-1:0]       image_height,
	output logic                              take,
	output ckc_pkg::s1_t                      s1_d,
	output logic                              re,
	output logic                              we0,
	output logic                              we1,
	output logic [$clog2(MAX_WIDTH)-1:0]      waddr,
	output logic [$clog2(MAX_WIDTH)-1:0]      raddr_a,
	output logic [$clog2(MAX_WIDTH)-1:0]      raddr_b
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int OROW_W = $clog2(MAX_HEIGHT);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
	localparam int EW     = $clog2(MAX_WIDTH + 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

	logic [COL_W-1:0]  in_col_q, out_col_q, in_col_d, out_col_d;
	logic [ROW_W-1:0]  in_row_q, in_row_d;
	logic [OROW_W-1:0] out_row_q, out_row_d;
	logic [EW-1:0]     eff_w;
	logic [ROW_W-1:0]  eff_h;
	logic push_ok, drain_ok, push_emit, interior;
	logic in_col_end, out_col_end, out_row_end;

	// register values out of range are clamped
	always_comb begin
		if (image_width == '0) begin
			eff_w = EW'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(image_width);
		end
		if (image_height == '0) begin
			eff_h = ROW_W'(1);
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			eff_h = ROW_W'(MAX_HEIGHT);
		end else begin
			eff_h = ROW_W'(image_height);
		end
	end

	// end of row and frame tests
	assign in_col_end  = (32'(in_col_q) + 32'd1) >= 32'(eff_w);
	assign out_col_end = (32'(out_col_q) + 32'd1) >= 32'(eff_w);
	assign out_row_end = (32'(out_row_q) + 32'd1) >= 32'(eff_h);

	// item decode: pushes past the frame and early drains are dropped
	assign push_ok   = (operation == ckc_pkg::OP_PUSH) && (in_row_q < eff_h);
	assign drain_ok  = (operation == ckc_pkg::OP_DRAIN) && (in_row_q >= eff_h)
		&& (32'(out_row_q) < 32'(eff_h));
	assign push_emit = push_ok && (in_row_q != '0);
	assign interior  = (in_row_q >= ROW_W'(2)) && (in_col_q != '0)
		&& ((32'(in_col_q) + 32'd2) <= 32'(eff_w));
	assign take      = push_emit || drain_ok;

	always_comb begin
		s1_d.drain    = drain_ok;
		s1_d.interior = push_emit && interior;
		s1_d.sel      = drain_ok ? out_row_q[0] : ~in_row_q[0];
		s1_d.last     = drain_ok && out_row_end && out_col_end;
	end

	// line buffer ports: bank by row parity, centre and right from the row above
	assign re      = accept && take;
	assign we0     = accept && push_ok && !in_row_q[0];
	assign we1     = accept && push_ok && in_row_q[0];
	assign waddr   = in_col_q;
	assign raddr_a = (operation == ckc_pkg::OP_DRAIN) ? out_col_q : in_col_q;
	assign raddr_b = (in_col_q == LAST_COL) ? '0 : in_col_q + 1'b1;

	// next position
	always_comb begin
		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (push_ok) begin
			if (push_emit) begin
				if (in_col_end) begin
					out_col_d = '0;
					out_row_d = OROW_W'(in_row_q);
				end else begin
					out_col_d = in_col_q + 1'b1;
					out_row_d = OROW_W'(in_row_q - 1'b1);
				end
			end
			if (in_col_end) begin
				in_col_d = '0;
				in_row_d = in_row_q + 1'b1;
			end else begin
				in_col_d = in_col_q + 1'b1;
			end
		end else if (drain_ok) begin
			if (out_row_end && out_col_end) begin
				in_col_d  = '0;
				in_row_d  = '0;
				out_col_d = '0;
				out_row_d = '0;
			end else if (out_col_end) begin
				out_col_d = '0;
				out_row_d = out_row_q + 1'b1;
			end else begin
				out_col_d = out_col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

endmodule

// ===== src/ckc_mac.sv =====
// kernel datapath: product stage, then sum, saturation and the result register
// depends on ckc_pkg
module ckc_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ckc_pkg::pix_t  left_px,
	input  ckc_pkg::pix_t  right_px,
	input  ckc_pkg::pix_t  top_px,
	input  ckc_pkg::pix_t  bottom_px,
	input  ckc_pkg::pix_t  centre_px,
	input  logic           interior,
	input  logic           last,
	input  ckc_pkg::coef_t coef,
	output logic           out_valid,
	input  logic           out_ready,
	output ckc_pkg::pix_t  out_px,
	output logic           out_last
);

	localparam int PW = ckc_pkg::PROD_W;
	localparam int SW = ckc_pkg::SUM_W;
	localparam int CW = ckc_pkg::CH_W;

	logic [2:0][CW-1:0]    tap_px   [5];
	logic signed [CW-1:0]  tap_coef [5];
	logic signed [PW-1:0]  prod_d   [3][5];
	logic signed [PW-1:0]  prod_s2  [3][5];
	logic signed [SW-1:0]  sum      [3];
	logic [2:0][CW-1:0]    sat;
	ckc_pkg::pix_t         centre_s2, out_px_q;
	logic valid_s2, interior_s2, last_s2, out_valid_q, out_last_q, out_adv;

	// taps in the order left, right, top, bottom, centre
	assign tap_px[0]   = left_px;
	assign tap_px[1]   = right_px;
	assign tap_px[2]   = top_px;
	assign tap_px[3]   = bottom_px;
	assign tap_px[4]   = centre_px;
	assign tap_coef[0] = coef.left;
	assign tap_coef[1] = coef.right;
	assign tap_coef[2] = coef.top;
	assign tap_coef[3] = coef.bottom;
	assign tap_coef[4] = coef.centre;

	// one small multiplier per tap and channel
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int t = 0; t < 5; t++) begin
				prod_d[k][t] = $signed({{(PW - CW){1'b0}}, tap_px[t][k]})
					* $signed({{(PW - CW){tap_coef[t][CW-1]}}, tap_coef[t]});
			end
		end
	end

	// handshake between stage two and the result register
	assign out_adv  = !out_valid_q || out_ready;
	assign in_ready = !valid_s2 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s2     <= prod_d;
			centre_s2   <= centre_px;
			interior_s2 <= interior;
			last_s2     <= last;
		end
	end

	// sum of five taps and clamp to a byte
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = SW'(prod_s2[k][0]) + SW'(prod_s2[k][1]) + SW'(prod_s2[k][2])
				+ SW'(prod_s2[k][3]) + SW'(prod_s2[k][4]);
			if (sum[k] < 0) begin
				sat[k] = '0;
			end else if (sum[k] > SW'(255)) begin
				sat[k] = '1;
			end else begin
				sat[k] = sum[k][CW-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			out_px_q   <= interior_s2 ? ckc_pkg::pix_t'(sat) : centre_s2;
			out_last_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_px    = out_px_q;
	assign out_last  = out_last_q;

endmodule

// ===== src/cross_kernel_convolution.sv =====
// top level of the cross kernel convolution: registers, line buffer banks, pipeline
// depends on ckc_pkg, ckc_ram, ckc_ctrl, ckc_mac and cross_kernel_convolution_macros.svh
//
//  channel   handshake             payload
//  input     in_valid / in_ready   operation, in_blue, in_green, in_red
//  result    out_valid / out_ready out_blue, out_green, out_red, frame_last
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per clock while out_ready stays high; a result leaves through the line buffer read,
// the product stage and the sum and clamp into the result register, the pixel itself one row later
// the rate is set by the two line buffer banks, each with one write and two reads
// the pipeline holds three items; once stage one, stage two and the result register are full,
// out_ready low drops in_ready in the same cycle
// reset clears the counters and loads the register defaults; no clearing pass,
// history entries are used only after they were written
`include "cross_kernel_convolution_macros.svh"

module cross_kernel_convolution #(
	parameter int MAX_WIDTH  = ckc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ckc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [ckc_pkg::CH_W-1:0]         in_blue,
	input  logic [ckc_pkg::CH_W-1:0]         in_green,
	input  logic [ckc_pkg::CH_W-1:0]         in_red,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ckc_pkg::CH_W-1:0]         out_blue,
	output logic [ckc_pkg::CH_W-1:0]         out_green,
	output logic [ckc_pkg::CH_W-1:0]         out_red,
	output logic                             frame_last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ckc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ckc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int PIX_W = $bits(ckc_pkg::pix_t);

	logic [ckc_pkg::IMG_W_W-1:0] image_width_q;
	logic [ckc_pkg::IMG_H_W-1:0] image_height_q;
	ckc_pkg::coef_t              coef_q;
	ckc_pkg::s1_t                s1_d, ctrl_s1;
	ckc_pkg::pix_t               in_px, bottom_s1, left_q, centre, right, top, res_px;
	ckc_pkg::pix_t               rd_a0, rd_b0, rd_a1, rd_b1;
	logic [COL_W-1:0]            waddr, raddr_a, raddr_b;
	logic accept, take, re, we0, we1, valid_s1, mac_ready, adv_s1;

	// configuration registers, written at any beat of the port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= ckc_pkg::IMG_W_RESET;
			image_height_q <= ckc_pkg::IMG_H_RESET;
			coef_q.left    <= ckc_pkg::COEF_EDGE_RESET;
			coef_q.right   <= ckc_pkg::COEF_EDGE_RESET;
			coef_q.top     <= ckc_pkg::COEF_EDGE_RESET;
			coef_q.bottom  <= ckc_pkg::COEF_EDGE_RESET;
			coef_q.centre  <= ckc_pkg::COEF_CENTRE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ckc_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[ckc_pkg::IMG_W_W-1:0];
				ckc_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[ckc_pkg::IMG_H_W-1:0];
				ckc_pkg::REG_COEF_LEFT:    coef_q.left    <= cfg_data[ckc_pkg::CH_W-1:0];
				ckc_pkg::REG_COEF_RIGHT:   coef_q.right   <= cfg_data[ckc_pkg::CH_W-1:0];
				ckc_pkg::REG_COEF_TOP:     coef_q.top     <= cfg_data[ckc_pkg::CH_W-1:0];
				ckc_pkg::REG_COEF_BOTTOM:  coef_q.bottom  <= cfg_data[ckc_pkg::CH_W-1:0];
				ckc_pkg::REG_COEF_CENTER:  coef_q.centre  <= cfg_data[ckc_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// input beat
	assign in_ready = !valid_s1 || mac_ready;
	assign accept   = in_valid && in_ready;
	assign in_px    = '{red: in_red, green: in_green, blue: in_blue};

	ckc_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.take         (take),
		.s1_d         (s1_d),
		.re           (re),
		.we0          (we0),
		.we1          (we1),
		.waddr        (waddr),
		.raddr_a      (raddr_a),
		.raddr_b      (raddr_b)
	);

	// line buffer, one bank per row parity
	ckc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_bank0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr),
		.wdata   (in_px),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a0),
		.rdata_b (rd_b0)
	);

	ckc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_bank1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr),
		.wdata   (in_px),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a1),
		.rdata_b (rd_b1)
	);

	// stage one: read data in the banks' output registers
	assign adv_s1 = valid_s1 && mac_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= take;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			ctrl_s1   <= s1_d;
			bottom_s1 <= in_px;
		end
	end

	// centre and right come from the row above, top from the row before it
	assign centre = ctrl_s1.sel ? rd_a1 : rd_a0;
	assign right  = ctrl_s1.sel ? rd_b1 : rd_b0;
	assign top    = ctrl_s1.sel ? rd_a0 : rd_a1;

	// left neighbour is the centre of the previous push in the same row
	always_ff @(posedge clk) begin
		if (adv_s1 && !ctrl_s1.drain) begin
			left_q <= centre;
		end
	end

	ckc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (mac_ready),
		.left_px   (left_q),
		.right_px  (right),
		.top_px    (top),
		.bottom_px (bottom_s1),
		.centre_px (centre),
		.interior  (ctrl_s1.interior),
		.last      (ctrl_s1.last),
		.coef      (coef_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_px    (res_px),
		.out_last  (frame_last)
	);

	assign out_blue  = res_px.blue;
	assign out_green = res_px.green;
	assign out_red   = res_px.red;

	// checks on the pipeline and the bank selection
	`CKC_ASSERT_IMP(a_one_bank_written, clk, arst_n, 1'b1, $onehot0({we0, we1}))
	`CKC_ASSERT_IMP(a_push_reads_other_bank, clk, arst_n, re && !s1_d.drain, s1_d.sel ? we0 : we1)
	`CKC_ASSERT_IMP(a_interior_is_push, clk, arst_n, accept && take, !(s1_d.interior && s1_d.drain))
	`CKC_ASSERT_NXT(a_s1_holds_on_stall, clk, arst_n, !in_ready, valid_s1 && $stable(ctrl_s1))

endmodule
